### hdl/xtd_pkg.sv
// Package with the constants and types shared by the XTEA decryption block.
`timescale 1ns / 1ps
`default_nettype none

package xtd_pkg;

  localparam int unsigned XtdRounds = 32;
  localparam logic [31:0] XtdDelta = 32'h9E37_79B9;
  localparam int unsigned XtdKeyWords = 4;
  localparam int unsigned XtdAddrW = 4;

  typedef logic [31:0] word_t;
  typedef word_t [XtdKeyWords-1:0] key_t;

  localparam key_t XtdKeyReset = {32'd6513004, 32'd1766613857, 32'd1818840163, 32'd1634494796};

  // Multiple of delta, modulo 2^32.
  function automatic word_t xtd_sum(input int unsigned mult);
    logic [63:0] prod;
    prod = 64'(mult) * 64'(XtdDelta);
    return prod[31:0];
  endfunction

endpackage : xtd_pkg

`default_nettype wire

### hdl/xtd_if.sv
// Stream interfaces for ciphertext and plaintext items.
`timescale 1ns / 1ps
`default_nettype none

interface xtd_cipher_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_low;
  logic [31:0] cipher_high;

  modport source (output valid, output cipher_low, output cipher_high, input ready);
  modport sink (input valid, input cipher_low, input cipher_high, output ready);
endinterface : xtd_cipher_if

interface xtd_plain_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_low;
  logic [31:0] plain_high;

  modport source (output valid, output plain_low, output plain_high, input ready);
  modport sink (input valid, input plain_low, input plain_high, output ready);
endinterface : xtd_plain_if

`default_nettype wire

### hdl/xtd_key_regs.sv
// APB register file holding the four 32-bit key words.
`timescale 1ns / 1ps
`default_nettype none

module xtd_key_regs
  import xtd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [XtdAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output key_t                     keys_o
);

  key_t keys_q;
  key_t keys_d;

  always_comb begin
    keys_d = keys_q;
    if (psel && penable && pwrite) begin
      keys_d[paddr[XtdAddrW-1:2]] = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= XtdKeyReset;
    end else begin
      keys_q <= keys_d;
    end
  end

  assign prdata = keys_q[paddr[XtdAddrW-1:2]];
  assign pready = 1'b1;
  assign keys_o = keys_q;

endmodule : xtd_key_regs

`default_nettype wire

### hdl/xtd_half_round.sv
// One pipeline stage performing half of an XTEA decryption round.
`timescale 1ns / 1ps
`default_nettype none

module xtd_half_round
  import xtd_pkg::*;
#(
  parameter bit    UpdHigh = 1'b1,
  parameter word_t SumC    = '0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire word_t v0_i,
  input  wire word_t v1_i,
  input  wire word_t key_i,
  output logic       valid_o,
  output word_t      v0_o,
  output word_t      v1_o
);

  word_t src;
  word_t mix;
  word_t f;
  word_t v0_d;
  word_t v1_d;
  word_t v0_q;
  word_t v1_q;
  logic  valid_q;

  always_comb begin
    src  = UpdHigh ? v0_i : v1_i;
    mix  = ((src << 4) ^ (src >> 5)) + src;
    f    = mix ^ (SumC + key_i);
    v0_d = UpdHigh ? v0_i : v0_i - f;
    v1_d = UpdHigh ? v1_i - f : v1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  assign valid_o = valid_q;
  assign v0_o    = v0_q;
  assign v1_o    = v1_q;

endmodule : xtd_half_round

`default_nettype wire

### hdl/xtd_out_skid.sv
// Skid buffer that decouples the pipeline from output backpressure.
`timescale 1ns / 1ps
`default_nettype none

module xtd_out_skid
  import xtd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  pipe_valid_i,
  input  wire word_t pipe_low_i,
  input  wire word_t pipe_high_i,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  output word_t      out_low_o,
  output word_t      out_high_o,
  output logic       en_o
);

  logic  skid_valid_q;
  logic  skid_valid_d;
  word_t skid_low_q;
  word_t skid_high_q;
  logic  capture;

  assign en_o    = !skid_valid_q;
  assign capture = en_o && pipe_valid_i && !out_ready_i;

  always_comb begin
    skid_valid_d = skid_valid_q;
    if (capture) begin
      skid_valid_d = 1'b1;
    end else if (skid_valid_q && out_ready_i) begin
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      skid_low_q  <= pipe_low_i;
      skid_high_q <= pipe_high_i;
    end
  end

  assign out_valid_o = skid_valid_q || pipe_valid_i;
  assign out_low_o   = skid_valid_q ? skid_low_q : pipe_low_i;
  assign out_high_o  = skid_valid_q ? skid_high_q : pipe_high_i;

endmodule : xtd_out_skid

`default_nettype wire

### hdl/xtea_block_decrypt.sv
// XTEA decryption top level: key registers, half-round pipeline and output skid buffer.
// Each half round is one pipeline stage.
// Throughput is one item per cycle; the pipeline pauses only while the output
// skid buffer holds an item that has not been taken.
// Reset clears all valid bits and the skid buffer and loads the default key words.
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_decrypt
  import xtd_pkg::*;
#(
  parameter int unsigned ROUNDS = XtdRounds
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  xtd_cipher_if.sink               cipher_i,
  xtd_plain_if.source              plain_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [XtdAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned NStg = 2 * ROUNDS;

  key_t        keys;
  logic        en;
  logic [NStg:0] valid;
  word_t       v0 [NStg+1];
  word_t       v1 [NStg+1];

  xtd_key_regs u_key_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .keys_o (keys)
  );

  assign valid[0]     = cipher_i.valid;
  assign v0[0]        = cipher_i.cipher_low;
  assign v1[0]        = cipher_i.cipher_high;
  assign cipher_i.ready = en;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam word_t SumHi = xtd_sum(ROUNDS - r);
    localparam word_t SumLo = xtd_sum(ROUNDS - r - 1);

    xtd_half_round #(
      .UpdHigh (1'b1),
      .SumC    (SumHi)
    ) u_hi (
      .clk_i,
      .rst_ni,
      .en_i    (en),
      .valid_i (valid[2*r]),
      .v0_i    (v0[2*r]),
      .v1_i    (v1[2*r]),
      .key_i   (keys[SumHi[12:11]]),
      .valid_o (valid[2*r+1]),
      .v0_o    (v0[2*r+1]),
      .v1_o    (v1[2*r+1])
    );

    xtd_half_round #(
      .UpdHigh (1'b0),
      .SumC    (SumLo)
    ) u_lo (
      .clk_i,
      .rst_ni,
      .en_i    (en),
      .valid_i (valid[2*r+1]),
      .v0_i    (v0[2*r+1]),
      .v1_i    (v1[2*r+1]),
      .key_i   (keys[SumLo[1:0]]),
      .valid_o (valid[2*r+2]),
      .v0_o    (v0[2*r+2]),
      .v1_o    (v1[2*r+2])
    );
  end

  xtd_out_skid u_out_skid (
    .clk_i,
    .rst_ni,
    .pipe_valid_i (valid[NStg]),
    .pipe_low_i   (v0[NStg]),
    .pipe_high_i  (v1[NStg]),
    .out_ready_i  (plain_o.ready),
    .out_valid_o  (plain_o.valid),
    .out_low_o    (plain_o.plain_low),
    .out_high_o   (plain_o.plain_high),
    .en_o         (en)
  );

endmodule : xtea_block_decrypt

`default_nettype wire

### verif/xtd_checker.sv
// Checker for the XTEA decryption block: predicts plaintext blocks and compares them, and checks key register reads.
`timescale 1ns / 1ps

module xtd_checker
  import xtd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  xtd_cipher_if                    cipher_mon,
  xtd_plain_if                     plain_mon,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [XtdAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  input  wire logic [31:0]         prdata,
  input  wire logic                pready,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);

  typedef struct packed {
    word_t low;
    word_t high;
  } plain_blk_t;

  plain_blk_t  expected_plain_q[$];
  key_t        key_copy;
  int unsigned fails;
  int unsigned checked;

  function automatic word_t feistel_mix(input word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic plain_blk_t decrypt_block(input word_t lo, input word_t hi,
                                               input key_t key);
    word_t v0;
    word_t v1;
    word_t total;
    v0 = lo;
    v1 = hi;
    total = XtdRounds * XtdDelta;
    for (int r = 0; r < XtdRounds; r++) begin
      v1 -= feistel_mix(v0) ^ (total + key[total[12:11]]);
      total -= XtdDelta;
      v0 -= feistel_mix(v1) ^ (total + key[total[1:0]]);
    end
    return '{low: v0, high: v1};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    plain_blk_t want;
    logic [1:0] reg_idx;
    if (!rst_ni) begin
      key_copy = XtdKeyReset;
      expected_plain_q.delete();
      fails = 0;
      checked = 0;
    end else begin
      if (plain_mon.valid && plain_mon.ready) begin
        if (expected_plain_q.size() == 0) begin
          $error("plain item with no block waiting: low %h, high %h",
                 plain_mon.plain_low, plain_mon.plain_high);
          fails++;
        end else begin
          want = expected_plain_q.pop_front();
          checked++;
          if (plain_mon.plain_low !== want.low) begin
            $error("plain_low mismatch: expected %h, actual %h", want.low,
                   plain_mon.plain_low);
            fails++;
          end
          if (plain_mon.plain_high !== want.high) begin
            $error("plain_high mismatch: expected %h, actual %h", want.high,
                   plain_mon.plain_high);
            fails++;
          end
        end
      end
      if (cipher_mon.valid && cipher_mon.ready) begin
        expected_plain_q = {expected_plain_q,
                            decrypt_block(cipher_mon.cipher_low,
                                          cipher_mon.cipher_high, key_copy)};
      end
      if (psel && penable && pready) begin
        reg_idx = paddr[XtdAddrW-1:2];
        if (pwrite) begin
          key_copy[reg_idx] = pwdata;
        end else if (prdata !== key_copy[reg_idx]) begin
          $error("key_word%0d mismatch: expected %h, actual %h", reg_idx,
                 key_copy[reg_idx], prdata);
          fails++;
        end
      end
    end
    fail_count_o <= fails;
    pending_o <= expected_plain_q.size();
    checked_o <= checked;
  end

endmodule : xtd_checker

### verif/tb_top.sv
// Testbench top for the XTEA decryption block: stimulus, key setup and verdict.
`timescale 1ns / 1ps

module tb_top;
  import xtd_pkg::*;

  typedef enum int unsigned {
    RegKeyWord0,
    RegKeyWord1,
    RegKeyWord2,
    RegKeyWord3
  } key_reg_e;

  localparam int unsigned PhaseBlocks = 125;
  localparam int unsigned NumPhases = 7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [XtdAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned blocks_sent;
  int unsigned reads_done;
  int unsigned key_sets;
  int unsigned rx_hold;
  bit          bursty;

  xtd_cipher_if cipher_ch ();
  xtd_plain_if  plain_ch ();

  xtea_block_decrypt dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cipher_i(cipher_ch),
    .plain_o (plain_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  xtd_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cipher_mon  (cipher_ch),
    .plain_mon   (plain_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      plain_ch.ready <= 1'b0;
    end else if (bursty && $urandom_range(0, 7) == 0) begin
      rx_hold <= $urandom_range(0, 5);
      plain_ch.ready <= 1'b0;
    end else begin
      plain_ch.ready <= 1'b1;
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input word_t lo, input word_t hi);
    if (bursty && $urandom_range(0, 4) == 0) begin
      cipher_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    cipher_ch.valid <= 1'b1;
    cipher_ch.cipher_low <= lo;
    cipher_ch.cipher_high <= hi;
    @(posedge clk_i);
    while (!cipher_ch.ready) @(posedge clk_i);
    blocks_sent++;
  endtask

  task automatic wait_drained();
    cipher_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic apb_access(input key_reg_e idx, input logic wr, input word_t data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= XtdAddrW'(int'(idx) * 4);
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (!wr) reads_done++;
  endtask

  task automatic read_back_key();
    for (int i = 0; i < XtdKeyWords; i++) apb_access(key_reg_e'(i), 1'b0, '0);
  endtask

  initial begin
    word_t directed_lo[14];
    word_t directed_hi[14];
    key_t  next_key;
    rst_ni = 1'b0;
    bursty = 1'b1;
    rx_hold = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cipher_ch.valid = 1'b0;
    cipher_ch.cipher_low = '0;
    cipher_ch.cipher_high = '0;
    plain_ch.ready = 1'b0;
    directed_lo = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h0123_4567, 32'hDEAD_BEEF,
                    32'h7FFF_FFFF, 32'hFFFF_FFFE};
    directed_hi = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                    32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000,
                    32'hAAAA_AAAA, 32'h5555_5555, 32'h89AB_CDEF, 32'hCAFE_F00D,
                    32'hFFFF_FFFE, 32'h7FFF_FFFF};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    read_back_key();
    key_sets = 1;
    foreach (directed_lo[i]) send_block(directed_lo[i], directed_hi[i]);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      for (int w = 0; w < XtdKeyWords; w++) begin
        case (p)
          0: next_key[w] = '0;
          1: next_key[w] = '1;
          default: next_key[w] = pick_word();
        endcase
        apb_access(key_reg_e'(w), 1'b1, next_key[w]);
      end
      read_back_key();
      key_sets++;
      bursty = (p != NumPhases - 1);
      for (int i = 0; i < PhaseBlocks; i++) begin
        if (i == PhaseBlocks / 2 && p == 2) wait_drained();
        send_block(pick_word(), pick_word());
      end
      wait_drained();
    end

    repeat (2 * XtdRounds + 8) @(posedge clk_i);
    $display("Sent %0d ciphertext blocks under %0d keys, all-zero and all-one included.",
             blocks_sent, key_sets);
    $display("Checked %0d plaintext blocks and %0d key register reads.", checked,
             reads_done);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d plaintext blocks still pending.", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule : tb_top
